/* rtl/triangular_quantile_defines.svh */
// assertion macros shared by the triangular quantile rtl
// included by files that carry concurrent checks; no other dependencies
`ifndef TRIANGULAR_QUANTILE_DEFINES_SVH
`define TRIANGULAR_QUANTILE_DEFINES_SVH

// same-cycle implication check, reset disables
`define TQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tq assertion failed");

// next-cycle implication check, reset disables
`define TQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tq assertion failed");

`endif

/* rtl/tq_pkg.sv */
// package for the triangular quantile block: constants, register codes, stage types
// no dependencies
`default_nettype none

package tq_pkg;

	// register indexes of the configuration port
	localparam logic [0:0] CFG_LOWER_TAIL = 1'b0;
	localparam logic [0:0] CFG_LOG_PROB   = 1'b1;

	// fixed point constants
	localparam logic [31:0] LN2_Q32     = 32'hB17217F7;
	localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
	localparam logic [24:0] ONE_Q24     = 25'h100_0000;
	localparam logic signed [33:0] ONE_Q24_S  = 34'sd16777216;
	localparam logic signed [33:0] OVER_Q24_S = 34'sd16777217;
	localparam logic [32:0] EXP_LIMIT   = 33'd301989888;

	// pipeline depths
	localparam int EXP_TERMS  = 12;
	localparam int DIV_STEPS  = 5;
	localparam int SQRT_STEPS = 32;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = 1;
	localparam int FIFO_CW    = 2;

	typedef struct packed {
		logic lower_tail;
		logic log_prob;
	} cfg_t;

	// front stage payload through classify, range reduction and series
	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic signed [31:0] pk;
		logic signed [31:0] p;
		logic               bad;
		logic               logp;
		logic               tail;
		logic               pos;
		logic               big;
		logic [4:0]         k;
		logic [40:0]        rem;
		logic [32:0]        t;
		logic [31:0]        v;
	} fr_t;

	// transaction handed from front to back
	typedef struct packed {
		logic [63:0]        x;
		logic signed [31:0] base;
		logic               sub;
		logic               na;
	} bk_t;

	// square root stage payload
	typedef struct packed {
		logic [63:0]        x;
		logic [63:0]        res;
		logic signed [31:0] base;
		logic               sub;
		logic               na;
	} sq_t;

endpackage

`default_nettype wire

/* rtl/tq_in_if.sv */
// input channel interface: probability and distribution parameters
// no dependencies
`default_nettype none

interface tq_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] prob;
	logic signed [31:0] lower_bound;
	logic signed [31:0] upper_bound;
	logic signed [31:0] peak;

	modport source (output valid, output prob, output lower_bound, output upper_bound,
		output peak, input ready);
	modport sink (input valid, input prob, input lower_bound, input upper_bound,
		input peak, output ready);
endinterface

`default_nettype wire

/* rtl/tq_out_if.sv */
// output channel interface: quantile and na flag
// no dependencies
`default_nettype none

interface tq_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] quantile;
	logic               na_flag;

	modport source (output valid, output quantile, output na_flag, input ready);
	modport sink (input valid, input quantile, input na_flag, output ready);
endinterface

`default_nettype wire

/* rtl/triangular_quantile.sv */
// top level of the triangular quantile block: config registers, front, queue, back
// uses tq_pkg, tq_in_if, tq_out_if, tq_front, tq_fifo, tq_back, assertion macros
//
// channel   dir  payload                                   width
// sample    in   prob, lower_bound, upper_bound, peak      4 x 32 signed
// result    out  quantile, na_flag                         32 signed, 1
// wr_*      in   wr_index selects lower_tail / log_prob    1, 1
//
// one transaction per cycle sustained while the queue has room and result.ready stays high;
// every stage of both pipelines is registered: 36 front stages (exp series and scaling
// multiplies), one queue entry, 34 back stages set by the 32 square root bit steps
// reset clears valid bits, queue pointers and config (lower_tail 1, log_prob 0)
// sample.ready drops only while the two-entry queue is full; the back stalls on result.ready
`default_nettype none
`include "triangular_quantile_defines.svh"

module triangular_quantile #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tq_in_if.sink           sample,
	tq_out_if.source        result,
	input  wire logic       wr_en,
	input  wire logic [0:0] wr_index,
	input  wire logic [0:0] wr_data
);
	import tq_pkg::*;

	cfg_t cfg_q;
	logic push, pop, full, empty;
	bk_t  push_data, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_tail <= 1'b1;
			cfg_q.log_prob   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_LOWER_TAIL: cfg_q.lower_tail <= wr_data[0];
				CFG_LOG_PROB:   cfg_q.log_prob   <= wr_data[0];
				default: ;
			endcase
		end
	end

	tq_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.sample(sample),
		.full(full),
		.push(push),
		.push_data(push_data)
	);

	tq_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	tq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	`TQ_ASSERT_IMP(a_na_zero, clk, arst_n, result.valid && result.na_flag,
		result.quantile == 32'sd0)
	`TQ_ASSERT_IMP(a_ready_tracks_queue, clk, arst_n, full, !sample.ready)
	`TQ_ASSERT_NXT(a_push_lands, clk, arst_n, push, !empty)

endmodule

`default_nettype wire

/* rtl/tq_front.sv */
// front part: accepts transactions, classifies parameters, evaluates exp,
// selects the side and forms the square root argument; uses tq_pkg, tq_in_if
`default_nettype none

module tq_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire tq_pkg::cfg_t cfg,
	tq_in_if.sink             sample,
	input  wire logic         full,
	output logic              push,
	output tq_pkg::bk_t       push_data
);
	import tq_pkg::*;

	localparam int VWE = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam int SH  = 32 - VWE;
	localparam int NFR = 1 + DIV_STEPS + 2 * EXP_TERMS;

	logic en;
	logic [NFR+5:0] vld_s;
	fr_t fr_s [0:NFR-1];
	fr_t fr_d [0:NFR-1];

	logic signed [31:0] lo_x, hi_x, pk_x;
	logic signed [32:0] m_neg;

	// the whole front moves together unless the queue is full
	assign en = !full;
	assign sample.ready = en;
	assign push = en && vld_s[NFR+5];

	// classify and prepare range reduction
	always_comb begin
		lo_x = $signed(sample.lower_bound << SH) >>> SH;
		hi_x = $signed(sample.upper_bound << SH) >>> SH;
		pk_x = $signed(sample.peak << SH) >>> SH;
		m_neg = 33'sd0 - $signed({sample.prob[31], sample.prob});
		fr_d[0].lo   = lo_x;
		fr_d[0].hi   = hi_x;
		fr_d[0].pk   = pk_x;
		fr_d[0].p    = sample.prob;
		fr_d[0].bad  = (lo_x >= hi_x) || (pk_x > hi_x) || (lo_x > pk_x);
		fr_d[0].logp = cfg.log_prob;
		fr_d[0].tail = cfg.lower_tail;
		fr_d[0].pos  = sample.prob > 32'sd0;
		fr_d[0].big  = $unsigned(m_neg) >= EXP_LIMIT;
		fr_d[0].k    = '0;
		fr_d[0].rem  = {m_neg, 8'd0};
		fr_d[0].t    = ONE_Q32;
		fr_d[0].v    = '0;
	end

	// k = floor(x / ln2), one quotient bit per stage
	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
		localparam int BP = DIV_STEPS - i;
		logic [40:0] sub_c;
		always_comb begin
			sub_c = {9'd0, LN2_Q32} << BP;
			fr_d[i] = fr_s[i-1];
			if (fr_s[i-1].rem >= sub_c) begin
				fr_d[i].rem   = fr_s[i-1].rem - sub_c;
				fr_d[i].k[BP] = 1'b1;
			end
		end
	end

	// horner series for exp(-r): multiply stage then divide-by-n stage
	for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
		localparam int N  = EXP_TERMS - j;
		localparam int IM = 1 + DIV_STEPS + 2 * j;
		localparam logic [63:0] RECIP = ((64'd1 << 36) + 64'(N) - 64'd1) / 64'(N);
		logic [64:0] prod_c;
		logic [68:0] quot_c;
		always_comb begin
			prod_c = fr_s[IM-1].rem[31:0] * fr_s[IM-1].t;
			fr_d[IM] = fr_s[IM-1];
			fr_d[IM].v = prod_c[63:32];
		end
		always_comb begin
			quot_c = fr_s[IM].v * RECIP[36:0];
			fr_d[IM+1] = fr_s[IM];
			fr_d[IM+1].t = ONE_Q32 - {1'b0, quot_c[67:36]};
		end
	end

	// front stage registers
	for (genvar i = 0; i < NFR; i++) begin : g_frreg
		always_ff @(posedge clk) begin
			if (en) begin
				fr_s[i] <= fr_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NFR+4:0], sample.valid};
		end
	end

	// scale exp result, tail flip and range check
	logic [5:0]         sh_c;
	logic [34:0]        rnd_c;
	logic [24:0]        ex_c;
	logic signed [33:0] qv_c;
	logic [24:0]        q_s30;
	logic [31:0]        len_s30, dl_s30, dh_s30;
	logic signed [31:0] lo_s30, hi_s30;
	logic               na_s30;

	always_comb begin
		sh_c  = 6'd8 + {1'b0, fr_s[NFR-1].k};
		rnd_c = ({2'b00, fr_s[NFR-1].t} + (35'd1 << (sh_c - 6'd1))) >> sh_c;
		ex_c  = fr_s[NFR-1].big ? 25'd0 : rnd_c[24:0];
		if (fr_s[NFR-1].logp) begin
			qv_c = fr_s[NFR-1].pos ? OVER_Q24_S : $signed({9'd0, ex_c});
		end else begin
			qv_c = $signed({{2{fr_s[NFR-1].p[31]}}, fr_s[NFR-1].p});
		end
		if (!fr_s[NFR-1].tail) begin
			qv_c = ONE_Q24_S - qv_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s30   <= qv_c[24:0];
			na_s30  <= fr_s[NFR-1].bad || (qv_c < 34'sd0) || (qv_c > ONE_Q24_S);
			len_s30 <= 32'(fr_s[NFR-1].hi - fr_s[NFR-1].lo);
			dl_s30  <= 32'(fr_s[NFR-1].pk - fr_s[NFR-1].lo);
			dh_s30  <= 32'(fr_s[NFR-1].hi - fr_s[NFR-1].pk);
			lo_s30  <= fr_s[NFR-1].lo;
			hi_s30  <= fr_s[NFR-1].hi;
		end
	end

	// side compare product q * len
	logic [56:0]        cmp_s31;
	logic [24:0]        q_s31;
	logic [31:0]        len_s31, dl_s31, dh_s31;
	logic signed [31:0] lo_s31, hi_s31;
	logic               na_s31;

	always_ff @(posedge clk) begin
		if (en) begin
			cmp_s31 <= q_s30 * len_s30;
			q_s31   <= q_s30;
			len_s31 <= len_s30;
			dl_s31  <= dl_s30;
			dh_s31  <= dh_s30;
			lo_s31  <= lo_s30;
			hi_s31  <= hi_s30;
			na_s31  <= na_s30;
		end
	end

	// pick the rising or the falling side
	logic               low_c;
	logic [31:0]        side_s32, len_s32;
	logic [24:0]        qq_s32;
	logic signed [31:0] base_s32;
	logic               sub_s32, na_s32;

	assign low_c = cmp_s31 < {1'b0, dl_s31, 24'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			side_s32 <= low_c ? dl_s31 : dh_s31;
			qq_s32   <= low_c ? q_s31 : ONE_Q24 - q_s31;
			base_s32 <= low_c ? lo_s31 : hi_s31;
			sub_s32  <= !low_c;
			len_s32  <= len_s31;
			na_s32   <= na_s31;
		end
	end

	// len * side
	logic [63:0]        ls_s33;
	logic [24:0]        qq_s33;
	logic signed [31:0] base_s33;
	logic               sub_s33, na_s33;

	always_ff @(posedge clk) begin
		if (en) begin
			ls_s33   <= len_s32 * side_s32;
			qq_s33   <= qq_s32;
			base_s33 <= base_s32;
			sub_s33  <= sub_s32;
			na_s33   <= na_s32;
		end
	end

	// partial products of the q24 scaling
	logic [56:0]        ph_s34, pl_s34;
	logic signed [31:0] base_s34;
	logic               sub_s34, na_s34;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s34   <= ls_s33[63:32] * qq_s33;
			pl_s34   <= ls_s33[31:0] * qq_s33;
			base_s34 <= base_s33;
			sub_s34  <= sub_s33;
			na_s34   <= na_s33;
		end
	end

	// combine partials into the root argument
	always_ff @(posedge clk) begin
		if (en) begin
			push_data.x    <= {ph_s34[55:0], 8'd0} + {31'd0, pl_s34[56:24]};
			push_data.base <= base_s34;
			push_data.sub  <= sub_s34;
			push_data.na   <= na_s34;
		end
	end

endmodule

`default_nettype wire

/* rtl/tq_fifo.sv */
// two-entry queue between front and back
// uses tq_pkg and the assertion macros header
`default_nettype none
`include "triangular_quantile_defines.svh"

module tq_fifo (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire tq_pkg::bk_t push_data,
	input  wire logic        pop,
	output tq_pkg::bk_t      head,
	output logic             full,
	output logic             empty
);
	import tq_pkg::*;

	bk_t                mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign full  = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rp_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`TQ_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`TQ_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty)
	`TQ_ASSERT_NXT(a_push_fills, clk, arst_n, push && !pop, !empty)

endmodule

`default_nettype wire

/* rtl/tq_back.sv */
// back part: pipelined integer square root and final add or subtract
// uses tq_pkg, tq_out_if
`default_nettype none

module tq_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tq_pkg::bk_t head,
	input  wire logic        empty,
	output logic             pop,
	tq_out_if.source         result
);
	import tq_pkg::*;

	logic en;
	logic [SQRT_STEPS:0] vld_s;
	sq_t  b_s [0:SQRT_STEPS];
	sq_t  b_d [1:SQRT_STEPS];
	logic signed [31:0] quant_s33;
	logic na_s33, ov_s33;
	logic [31:0] root_c;

	// back moves unless a finished result is held
	assign en  = !ov_s33 || result.ready;
	assign pop = en && !empty;

	always_ff @(posedge clk) begin
		if (en) begin
			b_s[0].x    <= head.x;
			b_s[0].res  <= '0;
			b_s[0].base <= head.base;
			b_s[0].sub  <= head.sub;
			b_s[0].na   <= head.na;
		end
	end

	// one root bit per stage
	for (genvar i = 1; i <= SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (64 - 2 * i);
		logic [63:0] trial_c;
		always_comb begin
			trial_c = b_s[i-1].res + BIT;
			b_d[i] = b_s[i-1];
			if (b_s[i-1].x >= trial_c) begin
				b_d[i].x   = b_s[i-1].x - trial_c;
				b_d[i].res = (b_s[i-1].res >> 1) + BIT;
			end else begin
				b_d[i].res = b_s[i-1].res >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				b_s[i] <= b_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			ov_s33 <= 1'b0;
		end else if (en) begin
			vld_s  <= {vld_s[SQRT_STEPS-1:0], !empty};
			ov_s33 <= vld_s[SQRT_STEPS];
		end
	end

	// offset from the chosen bound
	assign root_c = b_s[SQRT_STEPS].res[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			na_s33 <= b_s[SQRT_STEPS].na;
			if (b_s[SQRT_STEPS].na) begin
				quant_s33 <= '0;
			end else if (b_s[SQRT_STEPS].sub) begin
				quant_s33 <= b_s[SQRT_STEPS].base - $signed(root_c);
			end else begin
				quant_s33 <= b_s[SQRT_STEPS].base + $signed(root_c);
			end
		end
	end

	assign result.valid    = ov_s33;
	assign result.quantile = quant_s33;
	assign result.na_flag  = na_s33;

endmodule

`default_nettype wire

/* tb/sv/tq_tb_if.sv */
// testbench copies of the channel interfaces are not needed; this file holds shared tb types
// no dependencies
`timescale 1ns / 1ps

package tq_tb_pkg;
	// expected outcome of one transaction
	typedef struct packed {
		logic signed [31:0] quantile;
		logic               na_flag;
	} tq_expect_t;
endpackage

/* tb/sv/tq_checker.sv */
// checker for the triangular quantile block: watches both channels, predicts, compares
// depends on tq_pkg, tq_tb_pkg, tq_in_if, tq_out_if
`timescale 1ns / 1ps

module tq_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tq_in_if                sample,
	tq_out_if               result,
	input  wire logic       wr_en,
	input  wire logic [0:0] wr_index,
	input  wire logic [0:0] wr_data,
	output int              fail_count,
	output int              pending
);
	import tq_pkg::*;
	import tq_tb_pkg::*;

	logic       lower_tail_q;
	logic       log_prob_q;
	tq_expect_t quantile_queue[$];

	// exp(-m) for m >= 0 in Q8.24, result in Q1.24
	function automatic longint unsigned exp_neg(input longint unsigned m);
		longint unsigned x, k, r, t, one;
		int sh;
		one = 64'h1_0000_0000;
		if (m >= (64'd18 << 24)) return 0;
		x = m << 8;
		k = x / 64'hB17217F7;
		r = x - k * 64'hB17217F7;
		t = one;
		for (int n = EXP_TERMS; n >= 1; n--)
			t = one - ((r * t) >> 32) / n;
		sh = 8 + int'(k);
		return (t + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// integer square root, floored
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// quantile of one transaction under the current register values
	function automatic tq_expect_t predict_quantile(input logic signed [31:0] p,
		input logic signed [31:0] lo, input logic signed [31:0] hi,
		input logic signed [31:0] pk);
		tq_expect_t e;
		longint q, res, one;
		longint unsigned len, side, prod, frac, s;
		one = 64'd1 << 24;
		e.quantile = '0;
		e.na_flag = 1'b1;
		if (lo >= hi || pk > hi || lo > pk) return e;
		if (log_prob_q) q = (p > 0) ? one + 1 : longint'(exp_neg(-longint'(p)));
		else q = p;
		if (!lower_tail_q) q = one - q;
		if (q < 0 || q > one) return e;
		len = longint'(hi) - longint'(lo);
		if (unsigned'(q) * len < ((longint'(pk) - longint'(lo)) << 24)) begin
			side = longint'(pk) - longint'(lo);
			frac = q;
		end else begin
			side = longint'(hi) - longint'(pk);
			frac = one - q;
		end
		prod = len * side;
		// floor(prod * frac / 2^24) split to stay within 64 bits
		s = root_floor((((prod >> 32) * frac) << 8) + (((prod & 64'hFFFF_FFFF) * frac) >> 24));
		if (frac == q && side == longint'(pk) - longint'(lo) &&
				unsigned'(q) * len < (side << 24))
			res = longint'(lo) + longint'(s);
		else
			res = longint'(hi) - longint'(s);
		e.quantile = res[31:0];
		e.na_flag = 1'b0;
		return e;
	endfunction

	// register mirror, prediction on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		tq_expect_t want;
		if (!arst_n) begin
			lower_tail_q <= 1'b1;
			log_prob_q <= 1'b0;
			fail_count <= 0;
			pending <= 0;
			quantile_queue.delete();
		end else begin
			if (wr_en) begin
				if (wr_index == CFG_LOWER_TAIL) lower_tail_q <= wr_data;
				else if (wr_index == CFG_LOG_PROB) log_prob_q <= wr_data;
			end
			if (sample.valid && sample.ready)
				quantile_queue.push_back(predict_quantile(sample.prob, sample.lower_bound,
					sample.upper_bound, sample.peak));
			if (result.valid && result.ready) begin
				if (quantile_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result transaction: quantile %h na %b",
							result.quantile, result.na_flag);
				end else begin
					want = quantile_queue.pop_front();
					if (want.quantile !== result.quantile || want.na_flag !== result.na_flag)
					begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected quantile %h na %b, got %h na %b",
								want.quantile, want.na_flag, result.quantile, result.na_flag);
					end
				end
			end
			pending <= quantile_queue.size();
		end
	end
endmodule

/* tb/sv/triangular_quantile_test.sv */
// top of the triangular quantile testbench: clock, reset, stimulus, verdict
// depends on tq_pkg, tq_in_if, tq_out_if, tq_checker, triangular_quantile
`timescale 1ns / 1ps

module triangular_quantile_test;
	import tq_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int DRAIN_CYCLES = 120;
	localparam int IDLE_LIMIT   = 2000;

	logic       clk;
	logic       arst_n;
	logic       wr_en;
	logic [0:0] wr_index;
	logic [0:0] wr_data;
	int         fail_count;
	int         pending;
	int         idle_cycles;
	bit         calm;

	tq_in_if  sample();
	tq_out_if result();

	triangular_quantile u_dut (.clk(clk), .arst_n(arst_n), .sample(sample), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data));

	tq_checker u_checker (.clk(clk), .arst_n(arst_n), .sample(sample), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data), .fail_count(fail_count),
		.pending(pending));

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// random receiver stalls in bursts
	initial begin
		int burst;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
				result.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 10);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// wait for all results, then for the pipeline to empty
	task automatic settle();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one transaction, with optional idle burst ahead of it
	task automatic send_sample(input logic [31:0] p, input logic [31:0] lo,
		input logic [31:0] hi, input logic [31:0] pk);
		logic ok;
		if (!calm && $urandom_range(0, 5) == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.prob <= p;
		sample.lower_bound <= lo;
		sample.upper_bound <= hi;
		sample.peak <= pk;
		// ready is stable between edges, so look at it mid cycle
		do begin
			@(negedge clk);
			ok = sample.ready;
			@(posedge clk);
		end while (!ok);
	endtask

	// random probability for the current mode; mostly in range
	function automatic logic [31:0] pick_prob(input logic log_mode);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'h0100_0000;
			2: return 32'h0;
			default: return log_mode ? -$urandom_range(0, 32'h1400_0000)
				: $urandom_range(0, 32'h0100_0000);
		endcase
	endfunction

	// random well-formed or broken parameter set
	task automatic send_random(input logic log_mode);
		logic signed [31:0] lo, hi, pk;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			lo = $urandom();
			hi = $urandom();
			pk = $urandom();
		end else begin
			if (sel < 4) begin
				lo = $urandom();
				hi = $urandom();
			end else begin
				lo = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
				hi = lo + $urandom_range(1, 32'h00FF_FFFF);
			end
			if (lo > hi) begin
				pk = lo;
				lo = hi;
				hi = pk;
			end
			if (lo == hi) hi = lo + 1;
			if (hi < lo) begin
				lo = 32'sh8000_0000;
				hi = 32'sh7FFF_FFFF;
			end
			case ($urandom_range(0, 5))
				0: pk = lo;
				1: pk = hi;
				default: pk = lo + ($urandom() % (longint'(hi) - longint'(lo) + 1));
			endcase
		end
		send_sample(pick_prob(log_mode), lo, hi, pk);
	endtask

	initial begin
		logic [1:0] modes[4];
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_LOWER_TAIL;
		wr_data = 1'b0;
		calm = 1'b0;
		sample.valid = 1'b0;
		sample.prob = '0;
		sample.lower_bound = '0;
		sample.upper_bound = '0;
		sample.peak = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, bad parameters, tails, log inputs
		send_sample(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000);
		send_sample(32'h0100_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000);
		send_sample(32'h0080_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
		send_sample(32'h00FF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(32'h0100_0001, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000);
		send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000);
		send_sample(32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000);
		send_sample(32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000);
		send_sample(32'h0080_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_sample(32'h0080_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_8000);
		send_sample(32'h0080_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
		send_sample(32'h0080_0000, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000);
		send_sample(32'h0040_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		sample.valid <= 1'b0;
		settle();
		write_reg(CFG_LOWER_TAIL, 1'b0);
		send_sample(32'h0040_0000, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		send_sample(32'h0000_0000, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		sample.valid <= 1'b0;
		settle();
		write_reg(CFG_LOG_PROB, 1'b1);
		send_sample(32'h0000_0000, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		send_sample(32'h0000_0001, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		send_sample(32'hEE00_0000, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		send_sample(32'hEDFF_FFFF, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		send_sample(32'h8000_0000, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		send_sample(32'hFF4E_8DE8, 32'h0000_0000, 32'h0004_0000, 32'h0001_0000);
		sample.valid <= 1'b0;
		settle();

		// random phases over every register setting
		modes = '{2'b01, 2'b11, 2'b00, 2'b10};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_LOWER_TAIL, modes[ph][0]);
			write_reg(CFG_LOG_PROB, modes[ph][1]);
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
				if (ph == 3 && i > RANDOM_ITEMS / 8) calm = 1'b1;
				send_random(modes[ph][1]);
			end
			sample.valid <= 1'b0;
			settle();
		end

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
